@@ rtl/hms_pkg.sv @@
package hms_pkg;

    // Sequence machine states
    typedef enum logic [2:0] {
        SEQ_IDLE    = 3'd0,
        SEQ_ENABLE  = 3'd1,
        SEQ_HOME    = 3'd2,
        SEQ_HOMED   = 3'd3,
        SEQ_MOVE    = 3'd4,
        SEQ_DELAY   = 3'd5,
        SEQ_MOVE2   = 3'd6,
        SEQ_DISABLE = 3'd7
    } seq_state_t;

    // Motor command machine states
    typedef enum logic [3:0] {
        MS_READY        = 4'd0,
        MS_ENABLE       = 4'd1,
        MS_ENABLE_WAIT  = 4'd2,
        MS_DISABLE      = 4'd3,
        MS_DISABLE_WAIT = 4'd4,
        MS_AGAINST      = 4'd5,
        MS_CLOCK        = 4'd6,
        MS_MOVE_WAIT    = 4'd7,
        MS_CONSPD       = 4'd8,
        MS_CONSPD_WAIT  = 4'd9,
        MS_STOP         = 4'd10,
        MS_STOP_WAIT    = 4'd11
    } drive_state_t;

    // Driver commands
    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_ENABLE       = 3'd1,
        CMD_DISABLE      = 3'd2,
        CMD_MOVE_AGAINST = 3'd3,
        CMD_MOVE_CW      = 3'd4,
        CMD_CONST_SPEED  = 3'd5,
        CMD_STOP         = 3'd6,
        CMD_STOP_DISABLE = 3'd7
    } cmd_t;

    // Classified driver replies
    localparam logic [2:0] RPL_NONE       = 3'd0;
    localparam logic [2:0] RPL_ENABLE_ACK = 3'd1;
    localparam logic [2:0] RPL_DISABLE_ACK = 3'd2;
    localparam logic [2:0] RPL_DONE_LOWER = 3'd3;
    localparam logic [2:0] RPL_DONE_UPPER = 3'd4;
    localparam logic [2:0] RPL_STOP_ACK   = 3'd5;

    // Button sample result
    typedef enum logic [1:0] {
        BTN_NONE = 2'd0,
        BTN_BOTH = 2'd1,
        BTN_ONE  = 2'd2
    } btn_t;

    // Configuration register indexes
    localparam logic [1:0] REG_MOVE_STEPS = 2'd0;
    localparam logic [1:0] REG_BTN_WINDOW = 2'd1;
    localparam logic [1:0] REG_PRE_DELAY  = 2'd2;

    localparam logic [9:0] BTN_WINDOW_RESET = 10'd100;

    // Lamp bit positions
    localparam int LAMP1_BIT = 0;
    localparam int LAMP2_BIT = 1;
    localparam int LAMP3_BIT = 2;

    typedef struct packed {
        logic        emergency_stop;
        logic        left_pin;
        logic        right_pin;
        logic        home_pin;
        logic [2:0]  reply_kind;
    } tick_in_t;

    typedef struct packed {
        logic [31:0] move_steps;
        logic [9:0]  both_button_window;
        logic [15:0] pre_move_delay;
    } cfg_t;

    typedef struct packed {
        seq_state_t   sequence_state;
        drive_state_t drive_state;
        logic [2:0]   lamps;
        cmd_t         command;
        logic [31:0]  command_steps;
    } tick_out_t;

endpackage

@@ rtl/hms_core.sv @@
module hms_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  hms_pkg::tick_in_t tick,
    input  hms_pkg::cfg_t     cfg,
    output hms_pkg::tick_out_t result
);
    import hms_pkg::*;

    seq_state_t   seq_reg, seq_next;
    drive_state_t motor_reg, motor_mid, motor_next;
    logic [10:0]  timer_reg, timer_next, timer_sampled, timer_inc;
    logic [15:0]  delay_reg, delay_next;
    logic [2:0]   lamp_reg, lamp_next;
    logic [10:0]  window_ext;
    logic         left_pressed, right_pressed, motor_ready;
    btn_t         btn;
    cmd_t         cmd;

    assign left_pressed  = ~tick.left_pin;
    assign right_pressed = ~tick.right_pin;
    assign window_ext    = {1'b0, cfg.both_button_window};
    assign motor_ready   = (motor_reg == MS_READY);
    assign timer_inc     = timer_reg + 11'd1;

    // Sample buttons against the two-button window
    always_comb
    begin
        btn           = BTN_NONE;
        timer_sampled = timer_reg;
        if (left_pressed && right_pressed && (timer_reg < window_ext))
        begin
            btn           = BTN_BOTH;
            timer_sampled = '0;
        end
        else if (!left_pressed && !right_pressed)
        begin
            timer_sampled = '0;
        end
        else if (left_pressed != right_pressed)
        begin
            btn           = BTN_ONE;
            timer_sampled = (timer_inc > window_ext) ? window_ext + 11'd1 : timer_inc;
        end
    end

    // Sequence machine next state, with the motor request it hands over
    always_comb
    begin
        seq_next   = seq_reg;
        motor_mid  = motor_reg;
        timer_next = timer_reg;
        delay_next = delay_reg;
        lamp_next  = lamp_reg;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                lamp_next  = 3'b001;
                timer_next = timer_sampled;
                if (btn == BTN_BOTH)
                begin
                    motor_mid = MS_ENABLE;
                    seq_next  = SEQ_ENABLE;
                end
            end
            SEQ_ENABLE:
            begin
                lamp_next = 3'b100;
                if (motor_ready)
                begin
                    if (!tick.home_pin)
                    begin
                        motor_mid = MS_CONSPD;
                        seq_next  = SEQ_HOME;
                    end
                    else
                    begin
                        seq_next = SEQ_HOMED;
                    end
                end
            end
            SEQ_HOME:
            begin
                if (motor_ready && tick.home_pin)
                begin
                    motor_mid = MS_STOP;
                    seq_next  = SEQ_HOMED;
                end
            end
            SEQ_HOMED:
            begin
                if (motor_ready)
                begin
                    motor_mid = MS_AGAINST;
                    seq_next  = SEQ_MOVE;
                end
            end
            SEQ_MOVE:
            begin
                if (motor_ready)
                begin
                    lamp_next[LAMP2_BIT] = 1'b1;
                    delay_next           = cfg.pre_move_delay;
                    seq_next             = SEQ_DELAY;
                end
            end
            SEQ_DELAY:
            begin
                if (delay_reg == '0)
                begin
                    lamp_next[LAMP2_BIT] = 1'b0;
                    motor_mid            = MS_CLOCK;
                    seq_next             = SEQ_MOVE2;
                end
                else
                begin
                    delay_next = delay_reg - 16'd1;
                end
            end
            SEQ_MOVE2:
            begin
                if (motor_ready)
                begin
                    motor_mid = MS_DISABLE;
                    seq_next  = SEQ_DISABLE;
                end
            end
            SEQ_DISABLE:
            begin
                // buttons are sampled only once the motor is ready
                if (motor_ready)
                begin
                    timer_next = timer_sampled;
                    if (btn == BTN_NONE)
                    begin
                        motor_mid = MS_DISABLE;
                        seq_next  = SEQ_IDLE;
                    end
                end
            end
        endcase
    end

    // Motor machine next state: issue, then wait for the matching reply
    always_comb
    begin
        motor_next = motor_mid;
        unique case (motor_mid)
            MS_READY:        motor_next = MS_READY;
            MS_ENABLE:       motor_next = MS_ENABLE_WAIT;
            MS_ENABLE_WAIT:  if (tick.reply_kind == RPL_ENABLE_ACK) motor_next = MS_READY;
            MS_DISABLE:      motor_next = MS_DISABLE_WAIT;
            MS_DISABLE_WAIT: if (tick.reply_kind == RPL_DISABLE_ACK) motor_next = MS_READY;
            MS_AGAINST:      motor_next = MS_MOVE_WAIT;
            MS_CLOCK:        motor_next = MS_MOVE_WAIT;
            MS_MOVE_WAIT:    if (tick.reply_kind == RPL_DONE_LOWER) motor_next = MS_READY;
            MS_CONSPD:       motor_next = MS_CONSPD_WAIT;
            MS_CONSPD_WAIT:  if (tick.reply_kind == RPL_DONE_UPPER) motor_next = MS_READY;
            MS_STOP:         motor_next = MS_STOP_WAIT;
            MS_STOP_WAIT:    if (tick.reply_kind == RPL_STOP_ACK) motor_next = MS_READY;
            default:         motor_next = MS_READY;
        endcase
    end

    // Motor machine output: command issued on entry to each request state
    always_comb
    begin
        unique case (motor_mid)
            MS_ENABLE:  cmd = CMD_ENABLE;
            MS_DISABLE: cmd = CMD_DISABLE;
            MS_AGAINST: cmd = CMD_MOVE_AGAINST;
            MS_CLOCK:   cmd = CMD_MOVE_CW;
            MS_CONSPD:  cmd = CMD_CONST_SPEED;
            MS_STOP:    cmd = CMD_STOP;
            default:    cmd = CMD_NONE;
        endcase
    end

    // Combine, with emergency stop overriding both machines
    always_comb
    begin
        result.command_steps = '0;
        if (tick.emergency_stop)
        begin
            result.sequence_state = SEQ_IDLE;
            result.drive_state    = MS_READY;
            result.lamps          = lamp_reg & ~(3'b1 << LAMP2_BIT);
            result.command        = CMD_STOP_DISABLE;
        end
        else
        begin
            result.sequence_state = seq_next;
            result.drive_state    = motor_next;
            result.lamps          = lamp_next;
            result.command        = cmd;
            if (cmd == CMD_MOVE_AGAINST || cmd == CMD_MOVE_CW)
            begin
                result.command_steps = cfg.move_steps;
            end
        end
    end

    // Advance machine state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_IDLE;
            motor_reg <= MS_READY;
            timer_reg <= '0;
            delay_reg <= '0;
            lamp_reg  <= '0;
        end
        else if (advance)
        begin
            seq_reg   <= result.sequence_state;
            motor_reg <= result.drive_state;
            lamp_reg  <= result.lamps;
            if (!tick.emergency_stop)
            begin
                timer_reg <= timer_next;
                delay_reg <= delay_next;
            end
        end
    end

endmodule

@@ rtl/homing_move_sequencer.sv @@
// Channel | Handshake               | Payload
// in      | in_valid / in_stall     | emergency_stop, left_pin, right_pin, home_pin, reply_kind
// out     | out_valid / out_stall   | sequence_state, drive_state, lamp_one..three,
//         |                         | command, command_steps
// cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One tick per clock while the output is not stalled; a request lands in the input register, and
// its result is loaded from there into the result register when that register can take it.
// The tick logic between them is the two state machines and the button timer.
// Reset clears both machines, the timer, the delay counter, the lamps and both valid flags.
// An output stall holds the result register; the input stage keeps taking a tick
// while the result register is empty or being drained.
module homing_move_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        emergency_stop,
    input  logic        left_pin,
    input  logic        right_pin,
    input  logic        home_pin,
    input  logic [2:0]  reply_kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  sequence_state,
    output logic [3:0]  drive_state,
    output logic        lamp_one,
    output logic        lamp_two,
    output logic        lamp_three,
    output logic [2:0]  command,
    output logic [31:0] command_steps,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hms_pkg::*;

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    tick_in_t  s1_tick_reg;
    logic      out_valid_reg;
    tick_out_t out_reg;
    tick_out_t result;
    logic      out_advance, s1_advance;

    assign cfg_ready   = 1'b1;
    assign out_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_stall    = !s1_advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_steps         <= '0;
            cfg_reg.both_button_window <= BTN_WINDOW_RESET;
            cfg_reg.pre_move_delay     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MOVE_STEPS: cfg_reg.move_steps         <= cfg_data;
                REG_BTN_WINDOW: cfg_reg.both_button_window <= cfg_data[9:0];
                REG_PRE_DELAY:  cfg_reg.pre_move_delay     <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Input register: take a request whenever the stage can move on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            s1_tick_reg.emergency_stop <= emergency_stop;
            s1_tick_reg.left_pin       <= left_pin;
            s1_tick_reg.right_pin      <= right_pin;
            s1_tick_reg.home_pin       <= home_pin;
            s1_tick_reg.reply_kind     <= reply_kind;
        end
    end

    hms_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (out_advance),
        .tick    (s1_tick_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sequence_state = out_reg.sequence_state;
    assign drive_state    = out_reg.drive_state;
    assign lamp_one       = out_reg.lamps[LAMP1_BIT];
    assign lamp_two       = out_reg.lamps[LAMP2_BIT];
    assign lamp_three     = out_reg.lamps[LAMP3_BIT];
    assign command        = out_reg.command;
    assign command_steps  = out_reg.command_steps;

    // Emergency stop leaves both machines at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == CMD_STOP_DISABLE)
        |-> (sequence_state == SEQ_IDLE) && (drive_state == MS_READY))
    else $error("stop command without idle machines");

    // Second lamp is lit only during the pre-move delay
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lamp_two |-> (sequence_state == SEQ_DELAY))
    else $error("second lamp outside delay");

    // Step count appears only with move commands
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command_steps != '0)
        |-> (command == CMD_MOVE_AGAINST) || (command == CMD_MOVE_CW))
    else $error("step count without move command");

    // An empty input stage never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
    else $error("stall with empty input stage");

endmodule
